### hw/rtl/bplp_pkg.sv
// Shared types and constants for the pixel line plotter.
// Holds field widths, command and mode codes, the controller state type and
// the pixel struct passed from the line stepper to the top level.
package bplp_pkg;

  localparam int TEXT_COLUMNS_DEF = 40;
  localparam int TEXT_ROWS_DEF    = 25;

  localparam int COORD_W    = 8;
  localparam int CELL_IDX_W = 10;
  localparam int CELL_W     = 8;
  localparam int CNT_W      = 7;
  // Error terms stay within [-510, 510], so twelve signed bits leave room.
  localparam int ERR_W      = 12;
  // Pixel cell index: at most 39 + 24 * 64.
  localparam int PIX_IDX_W  = 11;
  // Wide enough to compare against any store depth up to 64 * 64.
  localparam int CMP_W      = 13;

  localparam logic signed [COORD_W-1:0] SCREEN_MAX_X = 8'sd79;
  localparam logic signed [COORD_W-1:0] SCREEN_MAX_Y = 8'sd49;

  localparam logic CMD_DRAW = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [1:0] MODE_SET    = 2'd0;
  localparam logic [1:0] MODE_CLEAR  = 2'd1;
  localparam logic [1:0] MODE_TOGGLE = 2'd2;
  localparam logic [1:0] MODE_KEEP   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_DATA,
    ST_STEP,
    ST_MODIFY,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      last;
  } pix_t;

endpackage

### hw/rtl/bplp_stepper.sv
// Bresenham line stepper: holds the walk state of one line and presents the
// current pixel. Depends on bplp_pkg for widths and the pixel struct.
module bplp_stepper (
  input  logic                               clk,
  input  logic                               load,
  input  logic                               advance,
  input  logic signed [bplp_pkg::COORD_W-1:0] start_x,
  input  logic signed [bplp_pkg::COORD_W-1:0] start_y,
  input  logic signed [bplp_pkg::COORD_W-1:0] end_x,
  input  logic signed [bplp_pkg::COORD_W-1:0] end_y,
  output bplp_pkg::pix_t                     pix
);

  localparam int CW = bplp_pkg::COORD_W;
  localparam int EW = bplp_pkg::ERR_W;

  logic signed [CW-1:0] x_r, y_r, xe_r, ye_r;
  logic signed [EW-1:0] err_r, dd2_r, d2min_r;
  logic                 sx_neg_r, sy_neg_r, xmajor_r;

  logic signed [CW:0]   ddx, ddy;
  logic [CW-1:0]        dx, dy;
  logic signed [EW-1:0] dx_e, dy_e, maj_e, min_e;
  logic                 xmajor;
  logic                 last;

  assign ddx = {end_x[CW-1], end_x} - {start_x[CW-1], start_x};
  assign ddy = {end_y[CW-1], end_y} - {start_y[CW-1], start_y};
  assign dx  = ddx[CW] ? CW'(-ddx) : ddx[CW-1:0];
  assign dy  = ddy[CW] ? CW'(-ddy) : ddy[CW-1:0];
  assign dx_e = {{(EW-CW){1'b0}}, dx};
  assign dy_e = {{(EW-CW){1'b0}}, dy};
  assign xmajor = (dx >= dy);
  assign maj_e  = xmajor ? dx_e : dy_e;
  assign min_e  = xmajor ? dy_e : dx_e;

  always_ff @(posedge clk) begin
    if (load) begin
      x_r      <= start_x;
      y_r      <= start_y;
      xe_r     <= end_x;
      ye_r     <= end_y;
      sx_neg_r <= ddx[CW];
      sy_neg_r <= ddy[CW];
      xmajor_r <= xmajor;
      err_r    <= maj_e - (min_e <<< 1);
      dd2_r    <= (maj_e <<< 1) - (min_e <<< 1);
      d2min_r  <= min_e <<< 1;
    end else if (advance) begin
      // The major axis moves every step; the minor one only when the error
      // term has gone negative.
      if (xmajor_r) begin
        x_r <= sx_neg_r ? x_r - CW'(1) : x_r + CW'(1);
        if (err_r[EW-1]) begin
          y_r <= sy_neg_r ? y_r - CW'(1) : y_r + CW'(1);
        end
      end else begin
        y_r <= sy_neg_r ? y_r - CW'(1) : y_r + CW'(1);
        if (err_r[EW-1]) begin
          x_r <= sx_neg_r ? x_r - CW'(1) : x_r + CW'(1);
        end
      end
      err_r <= err_r[EW-1] ? err_r + dd2_r : err_r - d2min_r;
    end
  end

  assign last     = xmajor_r ? (x_r == xe_r) : (y_r == ye_r);
  // The final pixel is always the end point itself.
  assign pix.x    = last ? xe_r : x_r;
  assign pix.y    = last ? ye_r : y_r;
  assign pix.last = last;

endmodule

### hw/rtl/block_pixel_line_plotter.sv
// Pixel line plotter: draws Bresenham lines into a character-cell frame
// buffer of 2x2-pixel blocks, and reads back single cell bytes.
// The input channel (in_*) takes one item: a line draw with two signed
// endpoints and a pixel mode (set, clear, toggle, or leave unchanged), or a
// read of one cell byte. Each item gives one result on the out_* channel:
// the cell byte for a read, or the count of on-screen pixels for a draw.
// Both channels hand over an item when valid is high and stall is low.
// One item is worked on at a time. A read's cell byte goes from the cell
// memory's read register to the result register and then to the output
// register. A draw steps through its pixels one by one: each written
// on-screen pixel needs a read and then a write of its cell, every other
// pixel only a step, and the item then finishes.
// A new item is accepted as soon as the previous result is in the output
// register, even while the receiver still stalls it; that item then waits
// to finish until the register is free.
// After reset the cell memory, TEXT_COLUMNS * TEXT_ROWS cells (1000 by
// default), is cleared one cell per cycle; in_stall stays high during
// that pass.
module block_pixel_line_plotter #(
  parameter int TEXT_COLUMNS = bplp_pkg::TEXT_COLUMNS_DEF,
  parameter int TEXT_ROWS    = bplp_pkg::TEXT_ROWS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_cmd,
  input  logic [1:0]                            in_pixel_mode,
  input  logic signed [bplp_pkg::COORD_W-1:0]   in_start_x,
  input  logic signed [bplp_pkg::COORD_W-1:0]   in_start_y,
  input  logic signed [bplp_pkg::COORD_W-1:0]   in_end_x,
  input  logic signed [bplp_pkg::COORD_W-1:0]   in_end_y,
  input  logic [bplp_pkg::CELL_IDX_W-1:0]       in_cell_index,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [bplp_pkg::CELL_W-1:0]           out_cell_value,
  output logic [bplp_pkg::CNT_W-1:0]            out_pixels_on_screen
);

  localparam int DEPTH  = TEXT_COLUMNS * TEXT_ROWS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW     = bplp_pkg::COORD_W;
  localparam int DW     = bplp_pkg::CELL_W;
  localparam int NW     = bplp_pkg::CNT_W;
  localparam int IW     = bplp_pkg::PIX_IDX_W;
  localparam int KW     = bplp_pkg::CMP_W;

  bplp_pkg::state_t state_r, state_nxt;

  logic [DW-1:0]     mem [DEPTH];
  logic [DW-1:0]     mem_q_r;
  logic              mem_rd_en;
  logic [ADDR_W-1:0] mem_rd_addr;
  logic              mem_wr_en;
  logic [ADDR_W-1:0] mem_wr_addr;
  logic [DW-1:0]     mem_wr_data;

  logic [ADDR_W-1:0] clr_cnt_r;
  logic [1:0]        mode_r;
  logic [NW-1:0]     cnt_r;
  logic [DW-1:0]     res_cell_r;
  logic              rd_ok_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [1:0]        bit_r;
  logic              last_r;
  logic              out_valid_r;
  logic [DW-1:0]     out_cell_r;
  logic [NW-1:0]     out_cnt_r;

  logic              accept;
  logic              read_ok;
  logic              step_load;
  logic              step_adv;
  logic              pix_take;
  logic              out_load;
  logic              out_free;
  logic              clr_done;

  bplp_pkg::pix_t    pix;
  logic              on_screen;
  logic [IW-1:0]     pix_idx;
  logic              in_store;
  logic              writable;
  logic [DW-1:0]     bit_mask;
  logic [DW-1:0]     mod_data;

  bplp_stepper u_stepper (
    .clk     (clk),
    .load    (step_load),
    .advance (step_adv),
    .start_x (in_start_x),
    .start_y (in_start_y),
    .end_x   (in_end_x),
    .end_y   (in_end_y),
    .pix     (pix)
  );

  // Pixel decode for the stepper's current position.
  assign on_screen = !pix.x[CW-1] && (pix.x <= bplp_pkg::SCREEN_MAX_X) &&
                     !pix.y[CW-1] && (pix.y <= bplp_pkg::SCREEN_MAX_Y);
  assign pix_idx   = IW'(pix.x[CW-2:1]) + IW'(pix.y[CW-2:1]) * IW'(TEXT_COLUMNS);
  assign in_store  = (KW'(pix_idx) < KW'(DEPTH));
  assign writable  = in_store && (mode_r != bplp_pkg::MODE_KEEP);

  assign read_ok   = (KW'(in_cell_index) < KW'(DEPTH));
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign clr_done  = (clr_cnt_r == ADDR_W'(DEPTH - 1));

  assign bit_mask  = DW'(1) << bit_r;

  always_comb begin
    case (mode_r)
      bplp_pkg::MODE_SET:    mod_data = mem_q_r | bit_mask;
      bplp_pkg::MODE_CLEAR:  mod_data = mem_q_r & ~bit_mask;
      bplp_pkg::MODE_TOGGLE: mod_data = mem_q_r ^ bit_mask;
      default:               mod_data = mem_q_r;
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bplp_pkg::ST_CLEAR: begin
        if (clr_done) begin
          state_nxt = bplp_pkg::ST_IDLE;
        end
      end
      bplp_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == bplp_pkg::CMD_READ) ? bplp_pkg::ST_RD_DATA
                                                     : bplp_pkg::ST_STEP;
        end
      end
      bplp_pkg::ST_RD_DATA: state_nxt = bplp_pkg::ST_FINISH;
      bplp_pkg::ST_STEP: begin
        if (on_screen && writable) begin
          state_nxt = bplp_pkg::ST_MODIFY;
        end else if (pix.last) begin
          state_nxt = bplp_pkg::ST_FINISH;
        end
      end
      bplp_pkg::ST_MODIFY: begin
        state_nxt = last_r ? bplp_pkg::ST_FINISH : bplp_pkg::ST_STEP;
      end
      bplp_pkg::ST_FINISH: begin
        if (out_free) begin
          state_nxt = bplp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = bplp_pkg::ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall    = 1'b1;
    step_load   = 1'b0;
    step_adv    = 1'b0;
    pix_take    = 1'b0;
    out_load    = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = ADDR_W'(pix_idx);
    mem_wr_en   = 1'b0;
    mem_wr_addr = wr_addr_r;
    mem_wr_data = mod_data;
    case (state_r)
      bplp_pkg::ST_CLEAR: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = clr_cnt_r;
        mem_wr_data = '0;
      end
      bplp_pkg::ST_IDLE: begin
        in_stall    = 1'b0;
        mem_rd_addr = ADDR_W'(in_cell_index);
        mem_rd_en   = in_valid && (in_cmd == bplp_pkg::CMD_READ) && read_ok;
        step_load   = in_valid && (in_cmd == bplp_pkg::CMD_DRAW);
      end
      bplp_pkg::ST_STEP: begin
        step_adv  = !pix.last;
        pix_take  = on_screen && writable;
        mem_rd_en = on_screen && writable;
      end
      bplp_pkg::ST_MODIFY: begin
        mem_wr_en = 1'b1;
      end
      bplp_pkg::ST_FINISH: begin
        out_load = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bplp_pkg::ST_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == bplp_pkg::ST_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r     <= in_pixel_mode;
      cnt_r      <= '0;
      res_cell_r <= '0;
      rd_ok_r    <= read_ok;
    end
    if (state_r == bplp_pkg::ST_RD_DATA) begin
      res_cell_r <= rd_ok_r ? mem_q_r : '0;
    end
    if ((state_r == bplp_pkg::ST_STEP) && on_screen) begin
      cnt_r <= cnt_r + NW'(1);
    end
    if (pix_take) begin
      wr_addr_r <= ADDR_W'(pix_idx);
      bit_r     <= {pix.y[0], pix.x[0]};
      last_r    <= pix.last;
    end
    if (out_load) begin
      out_cell_r <= res_cell_r;
      out_cnt_r  <= cnt_r;
    end
  end

  // Cell memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_q_r <= mem[mem_rd_addr];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_cell_value       = out_cell_r;
  assign out_pixels_on_screen = out_cnt_r;

  // A pixel write always completes a read of the same cell in the previous cycle.
  a_rmw_pair: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bplp_pkg::ST_MODIFY) |->
      ($past(mem_rd_en) && ($past(mem_rd_addr) == mem_wr_addr)))
    else $error("cell write without matching read");

  // Nothing is written to the memory while waiting for an item.
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == bplp_pkg::ST_IDLE) |-> !mem_wr_en)
    else $error("memory write while idle");

  // A result loaded into an empty output register always raises out_valid.
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && !out_valid_r) |=> out_valid_r)
    else $error("result lost on load");

  // A result carries either a cell byte or a pixel count, never both.
  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_cell_r == '0) || (out_cnt_r == '0)))
    else $error("result holds both a cell byte and a count");

endmodule
